### design/ers_pkg.sv
// ers_pkg: shared types and codes for the elevator request scheduler
// no dependencies; imported by elevator_request_scheduler_unit
`default_nettype none

package ers_pkg;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_LAST,
    S_DECIDE,
    S_FETCH,
    S_OUT
  } ers_state_t;

  typedef logic [2:0] ers_status_t;

  localparam ers_status_t ST_SERVED   = 3'd0;
  localparam ers_status_t ST_EMPTY    = 3'd1;
  localparam ers_status_t ST_INSERTED = 3'd2;
  localparam ers_status_t ST_FULL     = 3'd3;
  localparam ers_status_t ST_DUP      = 3'd4;

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_SERVE = 1'b1;

  localparam int TIME_W   = 16;
  localparam int PLAT_W   = 2;
  localparam int SECTOR_W = 6;
  localparam int TAG_W    = 16;

endpackage

`default_nettype wire

### design/elevator_request_scheduler_unit.sv
// elevator_request_scheduler_unit: scan elevator scheduler over a request table
// depends on ers_pkg
//
// channel   direction  handshake         payload
// command   in         start, busy       opcode, arrival_time, is_write, platter,
//                                        track, sector, data_tag
// result    out        done (one cycle)  status, out_is_write, out_platter, out_track,
//                                        out_sector, out_tag, sweep_down, seek
//
// every add, and every serve of a non-empty table, sweeps the table once through one
// read port and one compare unit, then answers with done; a serve of an empty table
// answers straight from idle, without a sweep
// busy is high while a transaction is in flight; done is not held off by anyone
// rst is synchronous: table empty, head on track zero, sweeping up
`default_nettype none

module elevator_request_scheduler_unit #(
  parameter int QUEUE_DEPTH = 32,
  parameter int TRACK_BITS  = 10
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic                   opcode,
  input  wire logic [15:0]            arrival_time,
  input  wire logic                   is_write,
  input  wire logic [1:0]             platter,
  input  wire logic [TRACK_BITS-1:0]  track,
  input  wire logic [5:0]             sector,
  input  wire logic [15:0]            data_tag,
  output logic                        done,
  output ers_pkg::ers_status_t        status,
  output logic                        out_is_write,
  output logic [1:0]                  out_platter,
  output logic [TRACK_BITS-1:0]       out_track,
  output logic [5:0]                  out_sector,
  output logic [15:0]                 out_tag,
  output logic                        sweep_down,
  output logic                        seek
);
  import ers_pkg::*;

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [TAG_W-1:0]      tag;
    logic [SECTOR_W-1:0]   sect;
    logic [TRACK_BITS-1:0] trk;
    logic [PLAT_W-1:0]     plat;
    logic                  wr;
    logic [TIME_W-1:0]     tm;
  } entry_t;

  ers_state_t state, state_next;

  entry_t mem [QUEUE_DEPTH];
  entry_t rd_data;
  entry_t in_entry;
  logic [IDX_W-1:0] rd_addr;
  logic             mem_we;

  logic [QUEUE_DEPTH-1:0] valid;
  logic [CNT_W-1:0]       count;
  logic [TRACK_BITS-1:0]  head;
  logic                   dir;
  logic                   op;

  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] rd_idx;
  logic             rd_live;
  logic [IDX_W-1:0] sel_slot;

  // scan results
  logic                  dup;
  logic                  free_found;
  logic [IDX_W-1:0]      free_slot;
  logic                  h_found;
  logic [IDX_W-1:0]      h_slot;
  logic [TIME_W-1:0]     h_time;
  logic                  u_found;
  logic [IDX_W-1:0]      u_slot;
  logic [TIME_W-1:0]     u_time;
  logic [TRACK_BITS-1:0] u_trk;
  logic                  d_found;
  logic [IDX_W-1:0]      d_slot;
  logic [TIME_W-1:0]     d_time;
  logic [TRACK_BITS-1:0] d_trk;

  ers_status_t add_status;
  logic        last_idx;
  logic        is_full;

  assign last_idx = (idx == IDX_W'(QUEUE_DEPTH - 1));
  assign is_full  = (count >= CNT_W'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    busy       = (state != S_IDLE);
    rd_addr    = (state == S_FETCH) ? sel_slot : idx;
    mem_we     = 1'b0;
    if (dup) begin
      add_status = ST_DUP;
    end else if (is_full) begin
      add_status = ST_FULL;
    end else begin
      add_status = ST_INSERTED;
    end
    unique case (state)
      S_IDLE: begin
        if (start && !(opcode == OP_SERVE && count == '0)) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (last_idx) begin
          state_next = S_LAST;
        end
      end
      S_LAST: begin
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (op == OP_ADD) begin
          mem_we     = (add_status == ST_INSERTED);
          state_next = S_IDLE;
        end else begin
          state_next = S_FETCH;
        end
      end
      S_FETCH: begin
        state_next = S_OUT;
      end
      S_OUT: begin
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // request table
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[free_slot] <= in_entry;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      count   <= '0;
      head    <= '0;
      dir     <= 1'b0;
      done    <= 1'b0;
      rd_live <= 1'b0;
      idx     <= '0;
    end else begin
      done    <= 1'b0;
      rd_live <= (state == S_SCAN);
      rd_idx  <= idx;

      // compare unit, one table entry per cycle
      if (rd_live && op == OP_ADD) begin
        if (valid[rd_idx] && rd_data.trk == in_entry.trk && rd_data.tm == in_entry.tm) begin
          dup <= 1'b1;
        end
        if (!valid[rd_idx] && !free_found) begin
          free_found <= 1'b1;
          free_slot  <= rd_idx;
        end
      end
      if (rd_live && op == OP_SERVE && valid[rd_idx]) begin
        if (rd_data.trk == head) begin
          if (!h_found || rd_data.tm < h_time) begin
            h_found <= 1'b1;
            h_slot  <= rd_idx;
            h_time  <= rd_data.tm;
          end
        end else if (rd_data.trk > head) begin
          if (!u_found || rd_data.trk < u_trk ||
              (rd_data.trk == u_trk && rd_data.tm < u_time)) begin
            u_found <= 1'b1;
            u_slot  <= rd_idx;
            u_time  <= rd_data.tm;
            u_trk   <= rd_data.trk;
          end
        end else begin
          if (!d_found || rd_data.trk > d_trk ||
              (rd_data.trk == d_trk && rd_data.tm < d_time)) begin
            d_found <= 1'b1;
            d_slot  <= rd_idx;
            d_time  <= rd_data.tm;
            d_trk   <= rd_data.trk;
          end
        end
      end

      case (state)
        S_IDLE: begin
          if (start) begin
            op          <= opcode;
            in_entry.tm   <= arrival_time;
            in_entry.wr   <= is_write;
            in_entry.plat <= platter;
            in_entry.trk  <= track;
            in_entry.sect <= sector;
            in_entry.tag  <= data_tag;
            idx         <= '0;
            dup         <= 1'b0;
            free_found  <= 1'b0;
            h_found     <= 1'b0;
            u_found     <= 1'b0;
            d_found     <= 1'b0;
            if (opcode == OP_SERVE && count == '0) begin
              status       <= ST_EMPTY;
              out_is_write <= 1'b0;
              out_platter  <= '0;
              out_track    <= '0;
              out_sector   <= '0;
              out_tag      <= '0;
              sweep_down   <= dir;
              seek         <= 1'b0;
              done         <= 1'b1;
            end
          end
        end
        S_SCAN: begin
          idx <= idx + IDX_W'(1);
        end
        S_DECIDE: begin
          if (op == OP_ADD) begin
            if (add_status == ST_INSERTED) begin
              valid[free_slot] <= 1'b1;
              count            <= count + CNT_W'(1);
            end
            status       <= add_status;
            out_is_write <= 1'b0;
            out_platter  <= '0;
            out_track    <= '0;
            out_sector   <= '0;
            out_tag      <= '0;
            sweep_down   <= dir;
            seek         <= 1'b0;
            done         <= 1'b1;
          end else if (h_found) begin
            sel_slot <= h_slot;
          end else if (!dir) begin
            if (u_found) begin
              sel_slot <= u_slot;
            end else begin
              dir      <= 1'b1;
              sel_slot <= d_slot;
            end
          end else begin
            if (d_found) begin
              sel_slot <= d_slot;
            end else begin
              dir      <= 1'b0;
              sel_slot <= u_slot;
            end
          end
        end
        S_OUT: begin
          valid[sel_slot] <= 1'b0;
          count           <= count - CNT_W'(1);
          head            <= rd_data.trk;
          status          <= ST_SERVED;
          out_is_write    <= rd_data.wr;
          out_platter     <= rd_data.plat;
          out_track       <= rd_data.trk;
          out_sector      <= rd_data.sect;
          out_tag         <= rd_data.tag;
          sweep_down      <= dir;
          seek            <= (rd_data.trk != head);
          done            <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // entry count tracks the valid bits
  assert property (@(posedge clk) disable iff (rst) count == CNT_W'($countones(valid)))
    else $error("entry count out of step with valid bits");

  assert property (@(posedge clk) disable iff (rst) count <= CNT_W'(QUEUE_DEPTH))
    else $error("entry count above table depth");

  // an accepted transaction keeps the block busy or answers next cycle
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> (busy || done))
    else $error("accepted transaction dropped");

  // only a served request can report a seek
  assert property (@(posedge clk) disable iff (rst) (done && status != ST_SERVED) |-> !seek)
    else $error("seek on a non-serve result");

  // a serve never leaves the table with more entries
  assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_SERVED) |-> (count == $past(count) - CNT_W'(1)))
    else $error("serve did not remove an entry");

endmodule

`default_nettype wire

### dv/tb_top.sv
// tb_top: self-checking testbench for elevator_request_scheduler_unit
// drives add and serve transactions, predicts each result with its own scan model
// depends on ers_pkg and elevator_request_scheduler_unit
`default_nettype none

module tb_top;
  import ers_pkg::*;

  localparam int DEPTH = 32;
  localparam int TRK_W = 10;
  localparam int CYCLE_LIMIT = 300000;

  typedef struct {
    logic [15:0]      tm;
    logic             wr;
    logic [1:0]       plat;
    logic [TRK_W-1:0] trk;
    logic [5:0]       sect;
    logic [15:0]      tag;
  } disk_req_t;

  typedef struct {
    ers_status_t      status;
    logic             wr;
    logic [1:0]       plat;
    logic [TRK_W-1:0] trk;
    logic [5:0]       sect;
    logic [15:0]      tag;
    logic             down;
    logic             seek;
  } sched_result_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             opcode = OP_ADD;
  logic [15:0]      arrival_time = '0;
  logic             is_write = 1'b0;
  logic [1:0]       platter = '0;
  logic [TRK_W-1:0] track = '0;
  logic [5:0]       sector = '0;
  logic [15:0]      data_tag = '0;
  logic             busy;
  logic             done;
  ers_status_t      status;
  logic             out_is_write;
  logic [1:0]       out_platter;
  logic [TRK_W-1:0] out_track;
  logic [5:0]       out_sector;
  logic [15:0]      out_tag;
  logic             sweep_down;
  logic             seek;

  // scheduler model state
  bit               req_valid [DEPTH];
  disk_req_t        req_table [DEPTH];
  logic [TRK_W-1:0] head_trk = '0;
  bit               sweep_dn = 1'b0;
  int               req_count = 0;

  sched_result_t    pending_results [$];
  sched_result_t    want_res;
  int               error_count = 0;
  int               idle_pct = 0;
  int               cycle_count = 0;

  elevator_request_scheduler_unit #(
    .QUEUE_DEPTH(DEPTH),
    .TRACK_BITS (TRK_W)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .opcode      (opcode),
    .arrival_time(arrival_time),
    .is_write    (is_write),
    .platter     (platter),
    .track       (track),
    .sector      (sector),
    .data_tag    (data_tag),
    .done        (done),
    .status      (status),
    .out_is_write(out_is_write),
    .out_platter (out_platter),
    .out_track   (out_track),
    .out_sector  (out_sector),
    .out_tag     (out_tag),
    .sweep_down  (sweep_down),
    .seek        (seek)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int earliest_slot(input logic [TRK_W-1:0] trk);
    int best;
    best = -1;
    for (int i = 0; i < DEPTH; i++) begin
      if (req_valid[i] && req_table[i].trk == trk) begin
        if (best < 0 || req_table[i].tm < req_table[best].tm) best = i;
      end
    end
    return best;
  endfunction

  function automatic bit nearest_track(input bit dn, output logic [TRK_W-1:0] trk);
    bit found;
    found = 1'b0;
    trk = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (req_valid[i]) begin
        if (!dn && req_table[i].trk > head_trk && (!found || req_table[i].trk < trk)) begin
          found = 1'b1;
          trk = req_table[i].trk;
        end else if (dn && req_table[i].trk < head_trk &&
                     (!found || req_table[i].trk > trk)) begin
          found = 1'b1;
          trk = req_table[i].trk;
        end
      end
    end
    return found;
  endfunction

  function automatic sched_result_t schedule_step(input logic op, input disk_req_t rq);
    sched_result_t    r;
    int               slot;
    logic [TRK_W-1:0] next_trk;
    r = '{default: '0};
    if (op == OP_ADD) begin
      r.status = ST_INSERTED;
      for (int i = 0; i < DEPTH; i++) begin
        if (req_valid[i] && req_table[i].trk == rq.trk && req_table[i].tm == rq.tm)
          r.status = ST_DUP;
      end
      if (r.status == ST_INSERTED && req_count >= DEPTH) r.status = ST_FULL;
      if (r.status == ST_INSERTED) begin
        slot = -1;
        for (int i = 0; i < DEPTH; i++) begin
          if (slot < 0 && !req_valid[i]) slot = i;
        end
        req_table[slot] = rq;
        req_valid[slot] = 1'b1;
        req_count++;
      end
      r.down = sweep_dn;
      return r;
    end
    if (req_count == 0) begin
      r.status = ST_EMPTY;
      r.down = sweep_dn;
      return r;
    end
    slot = earliest_slot(head_trk);
    if (slot < 0) begin
      // nothing on the head track: take the nearest track ahead, else turn the sweep around
      if (!nearest_track(sweep_dn, next_trk)) begin
        sweep_dn = ~sweep_dn;
        void'(nearest_track(sweep_dn, next_trk));
      end
      slot = earliest_slot(next_trk);
    end
    r.status = ST_SERVED;
    r.wr = req_table[slot].wr;
    r.plat = req_table[slot].plat;
    r.trk = req_table[slot].trk;
    r.sect = req_table[slot].sect;
    r.tag = req_table[slot].tag;
    r.down = sweep_dn;
    r.seek = (req_table[slot].trk != head_trk);
    req_valid[slot] = 1'b0;
    req_count--;
    head_trk = req_table[slot].trk;
    return r;
  endfunction

  function automatic disk_req_t rand_req();
    disk_req_t rq;
    int        pick;
    rq.wr = 1'($urandom_range(1));
    rq.plat = 2'($urandom_range(3));
    rq.sect = 6'($urandom_range(63));
    rq.tag = 16'($urandom_range(16'hffff));
    case ($urandom_range(3))
      0: rq.trk = TRK_W'($urandom_range(15));
      1: rq.trk = TRK_W'($urandom_range(1023, 1008));
      default: rq.trk = TRK_W'($urandom_range(1023));
    endcase
    rq.tm = $urandom_range(1) ? 16'($urandom_range(7)) : 16'($urandom_range(16'hffff));
    // sometimes reuse a stored track and time to provoke a duplicate
    pick = $urandom_range(DEPTH - 1);
    if ($urandom_range(7) == 0 && req_valid[pick]) begin
      rq.trk = req_table[pick].trk;
      rq.tm = req_table[pick].tm;
    end
    return rq;
  endfunction

  task automatic issue_request(input logic op, input disk_req_t rq);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    opcode <= op;
    arrival_time <= rq.tm;
    is_write <= rq.wr;
    platter <= rq.plat;
    track <= rq.trk;
    sector <= rq.sect;
    data_tag <= rq.tag;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(schedule_step(op, rq));
  endtask

  task automatic add_req(input logic [15:0] tm, input logic wr, input logic [1:0] plat,
                         input logic [TRK_W-1:0] trk, input logic [5:0] sect,
                         input logic [15:0] tag);
    disk_req_t rq;
    rq.tm = tm;
    rq.wr = wr;
    rq.plat = plat;
    rq.trk = trk;
    rq.sect = sect;
    rq.tag = tag;
    issue_request(OP_ADD, rq);
  endtask

  task automatic serve_next();
    issue_request(OP_SERVE, rand_req());
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk);
  endtask

  task automatic test_directed();
    idle_pct = 0;
    serve_next();
    add_req(16'h0000, 1'b0, 2'd0, 10'd0, 6'd0, 16'h0000);
    add_req(16'hffff, 1'b1, 2'd3, 10'd1023, 6'd63, 16'hffff);
    add_req(16'hffff, 1'b0, 2'd1, 10'd1023, 6'd5, 16'h1234);
    add_req(16'd5, 1'b1, 2'd2, 10'd0, 6'd10, 16'h0005);
    add_req(16'd2, 1'b0, 2'd1, 10'd0, 6'd20, 16'h0002);
    add_req(16'd9, 1'b1, 2'd0, 10'd100, 6'd30, 16'h0100);
    add_req(16'd9, 1'b0, 2'd2, 10'd50, 6'd40, 16'h0050);
    add_req(16'd3, 1'b1, 2'd1, 10'd50, 6'd41, 16'h0051);
    repeat (7) serve_next();
    // head at the top: a lower track turns the sweep down
    add_req(16'd40, 1'b0, 2'd0, 10'd200, 6'd1, 16'h0200);
    add_req(16'd4, 1'b1, 2'd3, 10'd200, 6'd2, 16'h0201);
    repeat (2) serve_next();
    add_req(16'd77, 1'b1, 2'd2, 10'd500, 6'd3, 16'h0500);
    serve_next();
    serve_next();
  endtask

  task automatic test_full_table();
    disk_req_t rq;
    idle_pct = 16;
    while (req_count < DEPTH) issue_request(OP_ADD, rand_req());
    issue_request(OP_ADD, rand_req());
    rq = rand_req();
    rq.trk = req_table[0].trk;
    rq.tm = req_table[0].tm;
    issue_request(OP_ADD, rq);
    while (req_count > 0) serve_next();
    serve_next();
  endtask

  task automatic test_random(input int n, input int pct);
    int add_pct;
    idle_pct = pct;
    add_pct = 60;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(39) == 0) add_pct = $urandom_range(1) ? 80 : 30;
      if ($urandom_range(99) < add_pct) issue_request(OP_ADD, rand_req());
      else serve_next();
    end
  endtask

  task automatic test_drain_pause();
    test_random(30, 46);
    wait_drained();
    test_random(30, 0);
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with no pending transaction, status %0h", $time, status);
        error_count++;
      end else begin
        want_res = pending_results.pop_front();
        check_field("status", 16'(want_res.status), 16'(status));
        check_field("out_is_write", 16'(want_res.wr), 16'(out_is_write));
        check_field("out_platter", 16'(want_res.plat), 16'(out_platter));
        check_field("out_track", 16'(want_res.trk), 16'(out_track));
        check_field("out_sector", 16'(want_res.sect), 16'(out_sector));
        check_field("out_tag", want_res.tag, out_tag);
        check_field("sweep_down", 16'(want_res.down), 16'(sweep_down));
        check_field("seek", 16'(want_res.seek), 16'(seek));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_full_table();
    test_random(250, 0);
    test_random(250, 46);
    test_random(250, 16);
    test_drain_pause();
    wait_drained();
    repeat (50) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire

### elevator_request_scheduler_unit.f
design/ers_pkg.sv
design/elevator_request_scheduler_unit.sv
dv/tb_top.sv
